[hw/rtl/utf16_to_utf8_encoder_assert.svh]
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define U2U8_CHECK_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define U2U8_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/u2u8_pkg.sv]
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Beat types, job queue entry, queue sizing and encoding constants.
// ---------------------------------------------------------------------------
package u2u8_pkg;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [15:0] SURR_MASK = 16'hF800;
	localparam logic [15:0] SURR_BASE = 16'hD800;
	localparam logic [15:0] LOW_MASK  = 16'hFC00;
	localparam logic [15:0] LOW_BASE  = 16'hDC00;
	localparam logic [15:0] MAX_1B    = 16'h007F;
	localparam logic [15:0] MAX_2B    = 16'h07FF;

	localparam logic [7:0] LEAD2     = 8'hC0;
	localparam logic [7:0] LEAD3     = 8'hE0;
	localparam logic [7:0] LEAD4     = 8'hF0;
	localparam logic [7:0] CONT      = 8'h80;
	localparam logic [7:0] CONT_MASK = 8'h3F;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} cu_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       unit_done;
		logic       string_done;
		logic       error;
	} u8_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            last;
		logic            err;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

[hw/rtl/u2u8_front.sv]
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder front end
// Accepts code units, tracks surrogate and discard state, builds byte jobs.
// ---------------------------------------------------------------------------
module u2u8_front import u2u8_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cu_valid,
	output logic   cu_stall,
	input  cu_t    cu_data,
	input  qstat_t qstat,
	output logic   push,
	output job_t   push_job
);

	logic [9:0]  held_high_bits_q, held_high_bits_n;
	logic        high_pending_q, high_pending_n;
	logic        discarding_q, discarding_n;
	logic        accept, emit, surr, is_low, last;
	logic [15:0] cu;
	logic [4:0]  plane;
	logic [20:0] val;

	assign cu_stall = qstat.full;
	assign accept   = cu_valid && !qstat.full;
	assign cu       = cu_data.code_unit;
	assign last     = cu_data.last_unit;
	assign surr     = (cu & SURR_MASK) == SURR_BASE;
	assign is_low   = (cu & LOW_MASK) == LOW_BASE;
	assign plane    = {1'b0, held_high_bits_q[9:6]} + 5'd1;
	assign val      = {plane, held_high_bits_q[5:0], cu[9:0]};

	always_comb begin
		emit             = 1'b0;
		push_job         = '0;
		held_high_bits_n = held_high_bits_q;
		high_pending_n   = high_pending_q;
		discarding_n     = discarding_q;
		push_job.last    = last;
		if (discarding_q) begin
			if (last) begin
				emit         = 1'b1;
				push_job.err = 1'b1;
				discarding_n = 1'b0;
			end
		end else if (high_pending_q) begin
			emit             = 1'b1;
			high_pending_n   = 1'b0;
			held_high_bits_n = '0;
			if (!is_low) begin
				push_job.err = 1'b1;
				discarding_n = !last;
			end else begin
				push_job.bytes[0] = LEAD4 | {5'b0, val[20:18]};
				push_job.bytes[1] = CONT | ({2'b0, val[17:12]} & CONT_MASK);
				push_job.bytes[2] = CONT | ({2'b0, val[11:6]} & CONT_MASK);
				push_job.bytes[3] = CONT | ({2'b0, val[5:0]} & CONT_MASK);
				push_job.last_idx = 2'd3;
			end
		end else if (surr) begin
			if (is_low || last) begin
				emit         = 1'b1;
				push_job.err = 1'b1;
				discarding_n = !last;
			end else begin
				held_high_bits_n = cu[9:0];
				high_pending_n   = 1'b1;
			end
		end else if (cu <= MAX_1B) begin
			emit              = 1'b1;
			push_job.bytes[0] = cu[7:0];
		end else if (cu <= MAX_2B) begin
			emit              = 1'b1;
			push_job.bytes[0] = LEAD2 | {3'b0, cu[10:6]};
			push_job.bytes[1] = CONT | ({2'b0, cu[5:0]} & CONT_MASK);
			push_job.last_idx = 2'd1;
		end else begin
			emit              = 1'b1;
			push_job.bytes[0] = LEAD3 | {4'b0, cu[15:12]};
			push_job.bytes[1] = CONT | ({2'b0, cu[11:6]} & CONT_MASK);
			push_job.bytes[2] = CONT | ({2'b0, cu[5:0]} & CONT_MASK);
			push_job.last_idx = 2'd2;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_high_bits_q <= '0;
			high_pending_q   <= 1'b0;
			discarding_q     <= 1'b0;
		end else if (accept) begin
			held_high_bits_q <= held_high_bits_n;
			high_pending_q   <= high_pending_n;
			discarding_q     <= discarding_n;
		end
	end

endmodule

[hw/rtl/u2u8_queue.sv]
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder job queue
// Short register queue of byte jobs between front end and back end.
// ---------------------------------------------------------------------------
module u2u8_queue import u2u8_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	input  logic   pop,
	output job_t   head,
	output qstat_t qstat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = cnt_q == '0;
	assign qstat.full  = cnt_q == QCNT_W'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/u2u8_back.sv]
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder back end
// Walks the head job byte by byte into a registered output beat.
// ---------------------------------------------------------------------------
module u2u8_back import u2u8_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  job_t   head,
	input  qstat_t qstat,
	output logic   pop,
	output logic   u8_valid,
	input  logic   u8_stall,
	output u8_t    u8_data
);

	logic [1:0] idx_q;
	logic       valid_q;
	u8_t        out_q;
	logic       load, fin;

	assign load     = (!valid_q || !u8_stall) && !qstat.empty;
	assign fin      = idx_q == head.last_idx;
	assign pop      = load && fin;
	assign u8_valid = valid_q;
	assign u8_data  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.utf8_byte   <= head.bytes[idx_q];
			out_q.unit_done   <= fin;
			out_q.string_done <= fin && head.last;
			out_q.error       <= head.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (!u8_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/utf16_to_utf8_encoder.sv]
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Converts a stream of UTF-16 code units into UTF-8 bytes with surrogate
// pairing and error reporting for invalid surrogate sequences.
// ---------------------------------------------------------------------------
// A new code unit is taken every cycle while the four-entry job queue has
// room. Each unit produces 0 to 4 output beats: a held high surrogate and
// units skipped after an error produce none (the string's last unit then
// gives an error beat), and an error produces one beat with a zero byte.
// The output port moves one byte per cycle while u8_stall is low, so a unit
// that encodes to n bytes takes n output beats. The first byte of a unit is
// written into the job queue by the accepting edge, then loaded from the
// queue head into the output register once that register is free.
// ---------------------------------------------------------------------------
module utf16_to_utf8_encoder import u2u8_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cu_valid,
	output logic cu_stall,
	input  cu_t  cu_data,
	output logic u8_valid,
	input  logic u8_stall,
	output u8_t  u8_data
);

	`include "utf16_to_utf8_encoder_assert.svh"

	qstat_t qstat;
	logic   push, pop;
	job_t   push_job, head;

	u2u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cu_valid (cu_valid),
		.cu_stall (cu_stall),
		.cu_data  (cu_data),
		.qstat    (qstat),
		.push     (push),
		.push_job (push_job)
	);

	u2u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	u2u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.u8_valid (u8_valid),
		.u8_stall (u8_stall),
		.u8_data  (u8_data)
	);

	`U2U8_CHECK_IMP(a_sdone_udone, u8_valid && u8_data.string_done, u8_data.unit_done, "string end not on unit end")
	`U2U8_CHECK_IMP(a_err_beat, u8_valid && u8_data.error, u8_data.unit_done && (u8_data.utf8_byte == 8'h00), "malformed error beat")
	`U2U8_CHECK_NEXT(a_pop_frees, pop && !push, !qstat.full, "queue full after pop")

endmodule
